FILE: hdl/mmtb_pkg.sv
// Shared types and constants for the transposed-B matrix multiply engine.
`timescale 1ns / 1ps
package mmtb_pkg;

  localparam int unsigned IDX_W   = 6;
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned MUL_W   = 32;
  localparam int unsigned PROD_W  = 38;
  localparam int unsigned KIND_W  = 2;

  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 56;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD_A  = 2'd0,
    KIND_LOAD_B  = 2'd1,
    KIND_COMPUTE = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BWRITE,
    ST_CALC,
    ST_DRAIN,
    ST_EMIT
  } state_e;

endpackage

FILE: hdl/mmtb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module mmtb_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/matrix_multiply_transposed_b.sv
// Top level of the matrix multiply engine with B held in transposed layout.
`timescale 1ns / 1ps
// Computes C[i][j] = sum over k of A[i][k]*B[j][k] for DIM x DIM signed Q8.8
// matrices, exact in signed Q22.16. A load A beat writes its element directly;
// B is stored as one word per k holding all DIM lanes, so a load B beat
// rewrites its lane by read-modify-write. A compute beat reads one A element
// and one B word per cycle for each k into DIM parallel multiply-accumulate
// lanes, drains the two-stage pipeline, then shifts the row out one column per
// output beat, waiting whenever the output side stalls. No new input beat is
// accepted while a B load or a compute is in progress. Loads or computes with
// an index at or above DIM and beats of unused kind are dropped without
// results.
module matrix_multiply_transposed_b #(
  parameter int unsigned DIM = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [5:0] row, [11:6] col, [27:12] value, [31:28] zero
  input  logic [mmtb_pkg::IN_DATA_W-1:0] s_axis_tdata_i,
  // [1:0] kind
  input  logic [mmtb_pkg::KIND_W-1:0]    s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [5:0] out_row, [11:6] out_col, [49:12] product_value, [55:50] zero
  output logic [mmtb_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic                           m_axis_tlast_o
);

  localparam int unsigned A_DEPTH = DIM * DIM;
  localparam int unsigned A_AW    = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
  localparam int unsigned KW      = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int unsigned VW      = mmtb_pkg::VALUE_W;
  localparam int unsigned IW      = mmtb_pkg::IDX_W;
  localparam int unsigned B_W     = DIM * VW;

  localparam logic [KW-1:0] K_LAST = KW'(DIM - 1);
  localparam logic [IW-1:0] J_LAST = IW'(DIM - 1);
  localparam logic [IW:0]   DIM_C  = (IW + 1)'(DIM);

  mmtb_pkg::state_e state_q, state_d;

  logic [IW-1:0]       in_row, in_col;
  logic [VW-1:0]       in_value;
  mmtb_pkg::kind_e     in_kind;
  logic                s_fire, row_ok, col_ok;

  logic                a_we;
  logic [A_AW-1:0]     a_waddr, a_raddr;
  logic [VW-1:0]       a_rdata;
  logic                b_we;
  logic [KW-1:0]       b_raddr;
  logic [B_W-1:0]      b_wdata, b_rdata;

  logic                start_bl, start_calc, issue, emit_ld;

  logic [IW-1:0]       bl_lane_q;
  logic [KW-1:0]       bl_addr_q;
  logic [VW-1:0]       bl_val_q;

  logic [IW-1:0]       row_q;
  logic [KW-1:0]       k_q;
  logic [IW-1:0]       j_q;
  logic                rd_v_q, mul_v_q;

  logic signed [mmtb_pkg::MUL_W-1:0]  prod_q [DIM];
  logic signed [mmtb_pkg::PROD_W-1:0] acc_q  [DIM];

  logic                out_v_q;
  logic [IW-1:0]       out_row_q, out_col_q;
  logic [mmtb_pkg::PROD_W-1:0] out_val_q;
  logic                out_last_q;

  assign in_row   = s_axis_tdata_i[IW-1:0];
  assign in_col   = s_axis_tdata_i[2*IW-1:IW];
  assign in_value = s_axis_tdata_i[2*IW+VW-1:2*IW];
  assign in_kind  = mmtb_pkg::kind_e'(s_axis_tuser_i);
  assign s_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign row_ok   = {1'b0, in_row} < DIM_C;
  assign col_ok   = {1'b0, in_col} < DIM_C;

  assign a_waddr = A_AW'(in_row * DIM + in_col);
  assign a_raddr = A_AW'(row_q * DIM + k_q);

  always_comb begin
    b_wdata = b_rdata;
    for (int l = 0; l < DIM; l++) begin
      if (bl_lane_q == IW'(l)) begin
        b_wdata[l*VW +: VW] = bl_val_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mmtb_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    s_axis_tready_o = 1'b0;
    a_we            = 1'b0;
    b_we            = 1'b0;
    b_raddr         = KW'(in_col);
    start_bl        = 1'b0;
    start_calc      = 1'b0;
    issue           = 1'b0;
    emit_ld         = 1'b0;
    unique case (state_q)
      mmtb_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_fire) begin
          case (in_kind)
            mmtb_pkg::KIND_LOAD_A: begin
              a_we = row_ok && col_ok;
            end
            mmtb_pkg::KIND_LOAD_B: begin
              if (row_ok && col_ok) begin
                start_bl = 1'b1;
                state_d  = mmtb_pkg::ST_BWRITE;
              end
            end
            mmtb_pkg::KIND_COMPUTE: begin
              if (row_ok) begin
                start_calc = 1'b1;
                state_d    = mmtb_pkg::ST_CALC;
              end
            end
            default: ;
          endcase
        end
      end
      mmtb_pkg::ST_BWRITE: begin
        b_we    = 1'b1;
        state_d = mmtb_pkg::ST_IDLE;
      end
      mmtb_pkg::ST_CALC: begin
        issue   = 1'b1;
        b_raddr = k_q;
        if (k_q == K_LAST) begin
          state_d = mmtb_pkg::ST_DRAIN;
        end
      end
      mmtb_pkg::ST_DRAIN: begin
        if (!rd_v_q && !mul_v_q) begin
          state_d = mmtb_pkg::ST_EMIT;
        end
      end
      mmtb_pkg::ST_EMIT: begin
        if (!out_v_q || m_axis_tready_i) begin
          emit_ld = 1'b1;
          if (j_q == J_LAST) begin
            state_d = mmtb_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = mmtb_pkg::ST_IDLE;
    endcase
  end

  mmtb_ram #(
    .WIDTH (VW),
    .DEPTH (A_DEPTH)
  ) u_a_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_waddr),
    .wdata_i (in_value),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  mmtb_ram #(
    .WIDTH (B_W),
    .DEPTH (DIM)
  ) u_b_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (bl_addr_q),
    .wdata_i (b_wdata),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q  <= 1'b0;
      mul_v_q <= 1'b0;
      k_q     <= '0;
      j_q     <= '0;
      out_v_q <= 1'b0;
    end else begin
      rd_v_q  <= issue;
      mul_v_q <= rd_v_q;
      if (start_calc) begin
        k_q <= '0;
        j_q <= '0;
      end else begin
        if (issue) begin
          k_q <= k_q + KW'(1);
        end
        if (emit_ld) begin
          j_q <= j_q + IW'(1);
        end
      end
      if (emit_ld) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_bl) begin
      bl_lane_q <= in_row;
      bl_addr_q <= KW'(in_col);
      bl_val_q  <= in_value;
    end
    if (start_calc) begin
      row_q <= in_row;
    end
    for (int l = 0; l < DIM; l++) begin
      if (rd_v_q) begin
        prod_q[l] <= $signed(a_rdata) * $signed(b_rdata[l*VW +: VW]);
      end
      if (start_calc) begin
        acc_q[l] <= '0;
      end else if (mul_v_q) begin
        acc_q[l] <= acc_q[l] + mmtb_pkg::PROD_W'(prod_q[l]);
      end else if (emit_ld) begin
        acc_q[l] <= (l == DIM - 1) ? '0 : acc_q[(l + 1) % DIM];
      end
    end
    if (emit_ld) begin
      out_row_q  <= row_q;
      out_col_q  <= j_q;
      out_val_q  <= acc_q[0];
      out_last_q <= (j_q == J_LAST);
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {
    (mmtb_pkg::OUT_DATA_W - 2*IW - mmtb_pkg::PROD_W)'(0),
    out_val_q, out_col_q, out_row_q
  };

endmodule
